>>> hdl/sobel_rgb_edge_magnitude_assert.svh
// ---------------------------------------------------------------------------
// Sobel RGB edge magnitude - assertion macros
// Shared concurrent assertion forms; each expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SOBEL_RGB_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_RGB_EDGE_MAGNITUDE_ASSERT_SVH

// same-cycle implication
`define SRE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sre assertion failed");

// next-cycle implication
`define SRE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sre assertion failed");

`endif

>>> hdl/sre_pkg.sv
// ---------------------------------------------------------------------------
// Sobel RGB edge magnitude - package
// Shared constants, word types, job format and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package sre_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int HEIGHT_LIMIT  = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int ROW_W      = 13;
	localparam int OROW_W     = 12;
	localparam int RES_W      = 11;
	localparam int GRAD_W     = 11;
	localparam int ABS_W      = 10;
	localparam int SQ_W       = 20;
	localparam int RAD_W      = 21;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_MAG,
		KIND_ZERO
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SQX,
		BK_SQY,
		BK_ROOT
	} back_state_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_word_t;

	typedef struct packed {
		logic [RES_W-1:0] red_out;
		logic [RES_W-1:0] green_out;
		logic [RES_W-1:0] blue_out;
		logic             last_of_frame;
	} out_word_t;

	typedef struct packed {
		kind_t                  kind;
		logic                   last;
		logic [23:0]            center;
		logic [2:0][GRAD_W-1:0] gx;
		logic [2:0][GRAD_W-1:0] gy;
	} job_t;

	// channel 0 red, 1 green, 2 blue
	function automatic logic [7:0] chan_of(input logic [23:0] p, input int unsigned k);
		return p[8*(2-k) +: 8];
	endfunction

	function automatic logic [ABS_W-1:0] abs_of(input logic [GRAD_W-1:0] g);
		logic [GRAD_W-1:0] n;
		n = g[GRAD_W-1] ? (GRAD_W'(0) - g) : g;
		return n[ABS_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/sre_front.sv
// ---------------------------------------------------------------------------
// Sobel front end
// Frame counters, line store, 3x3 window, border classification, gradients.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sobel_rgb_edge_magnitude_assert.svh"

module sre_front #(
	parameter int MAX_WIDTH = sre_pkg::DEF_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sre_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [sre_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  sre_pkg::in_word_t                pix_word,
	output logic                             push,
	output sre_pkg::job_t                    push_job,
	input  logic                             q_full
);
	import sre_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;
	logic [CW-1:0]     eff_w, last_col, lim_col;
	logic [ROW_W-1:0]  eff_h, last_row, lim_row;
	logic [ROW_W-1:0]  in_row_q;
	logic [AW-1:0]     in_col_q;
	logic [OROW_W-1:0] out_row_q;
	logic [AW-1:0]     out_col_q;

	logic accept, cfg_wr, is_drain, pix_act, drn_act, emit, is_last;
	kind_t kind;

	// stage 1
	logic        s1_v_q, fire;
	logic        pix_act_s1, emit_s1, last_s1, drain_s1, up_ok_s1, mid_ok_s1;
	kind_t       kind_s1;
	logic [23:0] pix_s1;
	logic [AW-1:0] col_s1;

	logic [47:0]   line_mem [MAX_WIDTH];
	logic [47:0]   rd_q;
	logic [AW-1:0] rd_addr;
	logic [23:0]   up_m, mid_m;
	logic [23:0]   win_q [9];
	logic [23:0]   win_n [9];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready &&
		(cfg_addr == REG_FRAME_WIDTH || cfg_addr == REG_FRAME_HEIGHT);

	always_comb begin
		if (fw_q < 11'd3)
			eff_w = CW'(3);
		else if (32'(fw_q) > 32'(MAX_WIDTH))
			eff_w = CW'(MAX_WIDTH);
		else
			eff_w = CW'(fw_q);
		if (fh_q < 13'd3)
			eff_h = ROW_W'(3);
		else if (32'(fh_q) > 32'(HEIGHT_LIMIT))
			eff_h = ROW_W'(HEIGHT_LIMIT);
		else
			eff_h = ROW_W'(fh_q);
	end
	assign last_col = eff_w - CW'(1);
	assign lim_col  = eff_w - CW'(2);
	assign last_row = eff_h - ROW_W'(1);
	assign lim_row  = eff_h - ROW_W'(2);

	// classify the incoming word
	assign pix_stall = s1_v_q && q_full;
	assign accept    = pix_valid && !pix_stall;
	assign is_drain  = (pix_word.cmd == CMD_DRAIN);
	assign pix_act   = !is_drain && (in_row_q < eff_h);
	assign drn_act   = is_drain && (in_row_q >= eff_h);
	assign emit      = drn_act || (pix_act && ((in_row_q >= ROW_W'(2)) ||
		(in_row_q == ROW_W'(1) && in_col_q != '0)));
	assign is_last   = (ROW_W'(out_row_q) == last_row) && (CW'(out_col_q) == last_col);

	always_comb begin
		if (out_row_q == '0 || out_col_q == '0)
			kind = KIND_PASS;
		else if (ROW_W'(out_row_q) <= lim_row && CW'(out_col_q) <= lim_col)
			kind = KIND_MAG;
		else
			kind = KIND_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= WIDTH_RESET;
			fh_q      <= HEIGHT_RESET;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_wr) begin
			if (cfg_addr == REG_FRAME_WIDTH)
				fw_q <= cfg_data[FW_W-1:0];
			else
				fh_q <= cfg_data;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (accept) begin
			if (pix_act) begin
				if (CW'(in_col_q) == last_col) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
			end
			if (emit) begin
				if (is_last) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else if (CW'(out_col_q) == last_col) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + OROW_W'(1);
				end else begin
					out_col_q <= out_col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else if (accept)
			s1_v_q <= 1'b1;
		else if (fire)
			s1_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_act_s1 <= pix_act;
			emit_s1    <= emit;
			last_s1    <= is_last;
			drain_s1   <= is_drain;
			kind_s1    <= kind;
			up_ok_s1   <= (in_row_q >= ROW_W'(2));
			mid_ok_s1  <= (in_row_q >= ROW_W'(1));
			pix_s1     <= {pix_word.red_in, pix_word.green_in, pix_word.blue_in};
			col_s1     <= in_col_q;
		end
	end

	// line store: {two rows back, one row back} per column
	assign fire    = s1_v_q && !q_full;
	assign rd_addr = is_drain ? '0 : in_col_q;

	always_ff @(posedge clk) begin
		if (fire && pix_act_s1)
			line_mem[col_s1] <= {mid_m, pix_s1};
		if (accept)
			rd_q <= line_mem[rd_addr];
	end

	assign up_m  = up_ok_s1  ? rd_q[47:24] : '0;
	assign mid_m = mid_ok_s1 ? rd_q[23:0]  : '0;

	always_comb begin
		for (int i = 0; i < 9; i++)
			win_n[i] = win_q[i];
		if (pix_act_s1) begin
			win_n[0] = win_q[1]; win_n[1] = win_q[2]; win_n[2] = up_m;
			win_n[3] = win_q[4]; win_n[4] = win_q[5]; win_n[5] = mid_m;
			win_n[6] = win_q[7]; win_n[7] = win_q[8]; win_n[8] = pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (fire) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= win_n[i];
		end
	end

	// gradients off the shifted window
	always_comb begin
		logic [9:0]  lsum, rsum, tsum, bsum;
		logic [11:0] dx, dy;
		push_job.kind   = kind_s1;
		push_job.last   = last_s1;
		push_job.center = drain_s1 ? rd_q[23:0] : win_n[4];
		for (int unsigned k = 0; k < 3; k++) begin
			lsum = 10'(chan_of(win_n[0], k)) + 10'({chan_of(win_n[3], k), 1'b0}) +
				10'(chan_of(win_n[6], k));
			rsum = 10'(chan_of(win_n[2], k)) + 10'({chan_of(win_n[5], k), 1'b0}) +
				10'(chan_of(win_n[8], k));
			tsum = 10'(chan_of(win_n[0], k)) + 10'({chan_of(win_n[1], k), 1'b0}) +
				10'(chan_of(win_n[2], k));
			bsum = 10'(chan_of(win_n[6], k)) + 10'({chan_of(win_n[7], k), 1'b0}) +
				10'(chan_of(win_n[8], k));
			dx = 12'(lsum) - 12'(rsum);
			dy = 12'(tsum) - 12'(bsum);
			push_job.gx[k] = dx[GRAD_W-1:0];
			push_job.gy[k] = dy[GRAD_W-1:0];
		end
	end

	assign push = fire && emit_s1;

	`SRE_ASSERT_IMP(a_col_range, 1'b1, CW'(in_col_q) < eff_w && CW'(out_col_q) < eff_w)

endmodule

`default_nettype wire

>>> hdl/sre_queue.sv
// ---------------------------------------------------------------------------
// Sobel job queue
// Small FIFO of gradient jobs between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sobel_rgb_edge_magnitude_assert.svh"

module sre_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sre_pkg::job_t push_job,
	input  logic          pop,
	output sre_pkg::job_t head,
	output logic          full,
	output logic          empty
);
	import sre_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	`SRE_ASSERT_IMP(a_no_overflow, push, !full || pop)
	`SRE_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

`default_nettype wire

>>> hdl/sre_back.sv
// ---------------------------------------------------------------------------
// Sobel back end
// Per-channel squares and bit-pair integer square root, result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sobel_rgb_edge_magnitude_assert.svh"

module sre_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sre_pkg::job_t      head,
	input  logic               empty,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output sre_pkg::out_word_t res_word
);
	import sre_pkg::*;

	back_state_t state_q, state_n;
	job_t        job_q;
	logic        load_direct, sq_x, sq_y, step, finish;
	logic        res_valid_q;
	out_word_t   res_word_q;

	logic [SQ_W-1:0]  sqa_q  [3];
	logic [RAD_W-1:0] v_q    [3];
	logic [RAD_W-1:0] root_q [3];
	logic [RAD_W-1:0] v_n    [3];
	logic [RAD_W-1:0] root_n [3];
	logic [RAD_W-1:0] bit_q;
	logic [ABS_W-1:0] ax [3];
	logic [ABS_W-1:0] ay [3];
	logic [RES_W-1:0] direct [3];

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop && head.kind == KIND_MAG)
					state_n = BK_SQX;
			end
			BK_SQX:  state_n = BK_SQY;
			BK_SQY:  state_n = BK_ROOT;
			BK_ROOT: begin
				if (bit_q[0])
					state_n = BK_IDLE;
			end
			default: state_n = BK_IDLE;
		endcase
	end

	// controls
	always_comb begin
		pop         = 1'b0;
		load_direct = 1'b0;
		sq_x        = 1'b0;
		sq_y        = 1'b0;
		step        = 1'b0;
		finish      = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop         = !empty && !res_valid_q;
				load_direct = pop && (head.kind != KIND_MAG);
			end
			BK_SQX:  sq_x = 1'b1;
			BK_SQY:  sq_y = 1'b1;
			BK_ROOT: begin
				step   = 1'b1;
				finish = bit_q[0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
	end

	always_comb begin
		logic [RAD_W-1:0] t;
		for (int k = 0; k < 3; k++) begin
			ax[k] = abs_of(job_q.gx[k]);
			ay[k] = abs_of(job_q.gy[k]);
			t = root_q[k] + bit_q;
			if (v_q[k] >= t) begin
				v_n[k]    = v_q[k] - t;
				root_n[k] = (root_q[k] >> 1) + bit_q;
			end else begin
				v_n[k]    = v_q[k];
				root_n[k] = root_q[k] >> 1;
			end
			direct[k] = (head.kind == KIND_PASS) ? RES_W'(chan_of(head.center, k)) : '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (sq_x)
				sqa_q[k] <= SQ_W'(ax[k]) * SQ_W'(ax[k]);
			if (sq_y) begin
				v_q[k]    <= RAD_W'(sqa_q[k]) + RAD_W'(SQ_W'(ay[k]) * SQ_W'(ay[k]));
				root_q[k] <= '0;
			end else if (step) begin
				v_q[k]    <= v_n[k];
				root_q[k] <= root_n[k];
			end
		end
		if (sq_y)
			bit_q <= RAD_W'(1) << (RAD_W - 1);
		else if (step)
			bit_q <= bit_q >> 2;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_direct || finish)
			res_valid_q <= 1'b1;
		else if (res_valid_q && !res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			res_word_q.red_out       <= direct[0];
			res_word_q.green_out     <= direct[1];
			res_word_q.blue_out      <= direct[2];
			res_word_q.last_of_frame <= head.last;
		end else if (finish) begin
			res_word_q.red_out       <= root_n[0][RES_W-1:0];
			res_word_q.green_out     <= root_n[1][RES_W-1:0];
			res_word_q.blue_out      <= root_n[2][RES_W-1:0];
			res_word_q.last_of_frame <= job_q.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	`SRE_ASSERT_IMP(a_busy_quiet, state_q != BK_IDLE, !res_valid_q)
	`SRE_ASSERT_NXT(a_root_done, finish, res_valid_q && state_q == BK_IDLE)

endmodule

`default_nettype wire

>>> hdl/sobel_rgb_edge_magnitude.sv
// Path: the front stage 1 register, the job queue, then the result register directly for
//   border pixels or after square, square-add and 11 root steps for interior pixels.
// Throughput: words are taken one per cycle while the 4-deep job queue has room; the
//   back end takes no new job until the receiver has accepted the previous result.
// Reset: counters, window and queue clear; size 640x480; line store is not cleared.
// ---------------------------------------------------------------------------
// Sobel RGB edge magnitude - top level
// Streaming 3x3 per-channel Sobel magnitude with decoupled front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module sobel_rgb_edge_magnitude #(
	parameter int MAX_WIDTH = sre_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sre_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [sre_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  sre_pkg::in_word_t              pix_word,
	output logic                           res_valid,
	input  logic                           res_stall,
	output sre_pkg::out_word_t             res_word
);
	import sre_pkg::*;

	logic push, pop, q_full, q_empty;
	job_t push_job, head;

	sre_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_word  (pix_word),
		.push      (push),
		.push_job  (push_job),
		.q_full    (q_full)
	);

	sre_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	sre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

`default_nettype wire

>>> sim/sobel_rgb_edge_magnitude_tb.sv
// ---------------------------------------------------------------------------
// Sobel RGB edge magnitude - testbench
// Drives pixel and drain words through the block, predicts each result with a
// local model of the window, line stores and border rules, and checks every
// result word in order across several frame sizes and idle patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sobel_rgb_edge_magnitude_tb;
	import sre_pkg::*;

	localparam int MAXW = DEF_MAX_WIDTH;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_addr = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	in_word_t pix_word = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_word_t res_word;

	sobel_rgb_edge_magnitude i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_word(pix_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
	);

	// predictor state
	logic [23:0] upper_line [MAXW];
	logic [23:0] middle_line [MAXW];
	logic [23:0] win [9];
	int unsigned in_r, in_c, out_r, out_c;
	logic [FW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;

	out_word_t expected_words [$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int unsigned eff_w();
		int unsigned w;
		w = width_reg;
		if (w < 3) w = 3;
		if (w > MAXW) w = MAXW;
		return w;
	endfunction

	function automatic int unsigned eff_h();
		int unsigned h;
		h = height_reg;
		if (h < 3) h = 3;
		if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
		return h;
	endfunction

	function automatic int unsigned isqrt(int unsigned v);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	function automatic int unsigned edge_mag(int k);
		int s [9];
		int gx, gy;
		for (int i = 0; i < 9; i++) s[i] = win[i][8*(2-k) +: 8];
		gx = (s[0] + 2*s[3] + s[6]) - (s[2] + 2*s[5] + s[8]);
		gy = (s[0] + 2*s[1] + s[2]) - (s[6] + 2*s[7] + s[8]);
		return isqrt(gx*gx + gy*gy);
	endfunction

	task automatic emit_expected(logic [23:0] center);
		int unsigned w, h, v [3];
		out_word_t o;
		logic last;
		w = eff_w();
		h = eff_h();
		last = (out_r == h - 1) && (out_c == w - 1);
		for (int k = 0; k < 3; k++) begin
			if (out_r == 0 || out_c == 0) v[k] = center[8*(2-k) +: 8];
			else if (out_r <= h - 2 && out_c <= w - 2) v[k] = edge_mag(k);
			else v[k] = 0;
		end
		o.red_out = v[0][RES_W-1:0];
		o.green_out = v[1][RES_W-1:0];
		o.blue_out = v[2][RES_W-1:0];
		o.last_of_frame = last;
		expected_words.push_back(o);
		if (last) begin
			in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		end else if (out_c + 1 >= w) begin
			out_c = 0; out_r++;
		end else begin
			out_c++;
		end
	endtask

	task automatic predict_word(in_word_t x);
		int unsigned w, h, ir, ic;
		logic [23:0] pix, up, mid;
		w = eff_w();
		h = eff_h();
		ir = in_r;
		ic = in_c;
		if (x.cmd == CMD_DRAIN) begin
			if (in_r >= h) emit_expected(middle_line[0]);
			return;
		end
		if (ir >= h || ic >= MAXW) return;
		pix = {x.red_in, x.green_in, x.blue_in};
		up = (ir >= 2) ? upper_line[ic] : 24'd0;
		mid = (ir >= 1) ? middle_line[ic] : 24'd0;
		upper_line[ic] = mid;
		middle_line[ic] = pix;
		win[0] = win[1]; win[1] = win[2]; win[2] = up;
		win[3] = win[4]; win[4] = win[5]; win[5] = mid;
		win[6] = win[7]; win[7] = win[8]; win[8] = pix;
		if (ic + 1 >= w) begin
			in_c = 0; in_r = ir + 1;
		end else begin
			in_c = ic + 1;
		end
		if (ir >= 2 || (ir == 1 && ic >= 1)) emit_expected(win[4]);
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				$error("unexpected result word %h", res_word);
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (res_word.red_out !== e.red_out) begin
					$error("red_out exp %0d got %0d", e.red_out, res_word.red_out);
					errors++;
				end
				if (res_word.green_out !== e.green_out) begin
					$error("green_out exp %0d got %0d", e.green_out, res_word.green_out);
					errors++;
				end
				if (res_word.blue_out !== e.blue_out) begin
					$error("blue_out exp %0d got %0d", e.blue_out, res_word.blue_out);
					errors++;
				end
				if (res_word.last_of_frame !== e.last_of_frame) begin
					$error("last_of_frame exp %0d got %0d", e.last_of_frame,
						res_word.last_of_frame);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// valid stays up across back-to-back words; callers that stop sending
	// go through wait_idle, which drops it
	task automatic send_word(in_word_t x);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_word <= x;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		predict_word(x);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		wait_idle();
		cfg_addr <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
		else height_reg = val[FH_W-1:0];
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_word_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_word_t x;
		x.cmd = CMD_PIXEL; x.red_in = r; x.green_in = g; x.blue_in = b;
		return x;
	endfunction

	function automatic in_word_t rand_pixel();
		return pixel($urandom, $urandom, $urandom);
	endfunction

	function automatic in_word_t drain_word();
		in_word_t x;
		x = '0;
		x.cmd = CMD_DRAIN;
		x.red_in = $urandom; x.green_in = $urandom; x.blue_in = $urandom;
		return x;
	endfunction

	// one full frame plus its drain; extra stray words test ignore paths
	task automatic run_frame(bit noisy);
		int unsigned n;
		n = eff_w() * eff_h();
		for (int unsigned i = 0; i < n; i++) begin
			if (noisy && $urandom_range(19) == 0) send_word(drain_word());
			send_word(rand_pixel());
		end
		if (noisy) send_word(rand_pixel());
		for (int unsigned i = 0; i <= eff_w(); i++) send_word(drain_word());
	endtask

	task automatic test_directed();
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 3);
		send_word(drain_word());
		// extremes: alternating 0/255 channels in a checkerboard give zero gradient
		for (int i = 0; i < 9; i++)
			send_word((i % 2) ? pixel(8'hff, 8'h00, 8'hff) : pixel(8'h00, 8'hff, 8'h00));
		send_word(pixel(8'h12, 8'h34, 8'h56)); // ignored while pending
		for (int i = 0; i < 4; i++) send_word(drain_word());
		send_word(drain_word());
		for (int i = 0; i < 9; i++)
			send_word((i < 3) ? pixel(8'hff, 8'hff, 8'hff) : pixel(8'h00, 8'h00, 8'h00));
		for (int i = 0; i < 4; i++) send_word(drain_word());
		wait_idle();
	endtask

	task automatic test_clamp();
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 1);
		run_frame(1'b1);
		wait_idle();
		// width clamps to 1024: the first row results appear after 1025 pixels
		write_reg(REG_FRAME_WIDTH, 2047);
		write_reg(REG_FRAME_HEIGHT, 3);
		for (int i = 0; i < 1100; i++) send_word(rand_pixel());
		wait_idle();
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 8191);
		for (int i = 0; i < 30; i++) send_word(rand_pixel());
		wait_idle();
	endtask

	// register write mid-frame restarts counters
	task automatic test_restart();
		write_reg(REG_FRAME_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 4);
		for (int i = 0; i < 11; i++) send_word(rand_pixel());
		wait_idle();
		write_reg(REG_FRAME_HEIGHT, 4);
		run_frame(1'b0);
		wait_idle();
	endtask

	task automatic test_random(int target);
		int start;
		start = items_sent;
		while (items_sent - start < target) begin
			write_reg(REG_FRAME_WIDTH, $urandom_range(3, 12));
			write_reg(REG_FRAME_HEIGHT, $urandom_range(3, 9));
			run_frame($urandom_range(3) == 0);
			if ($urandom_range(3) == 0) wait_idle();
		end
		wait_idle();
	endtask

	initial begin
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		for (int i = 0; i < 9; i++) win[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_clamp();
		test_restart();
		send_idle_pct = 0; stall_pct = 0;
		test_random(120);
		send_idle_pct = 45; stall_pct = 0;
		test_random(120);
		send_idle_pct = 0; stall_pct = 45;
		test_random(120);
		send_idle_pct = 23; stall_pct = 23;
		test_random(120);
		send_idle_pct = 0; stall_pct = 0;
		test_random(80);

		wait_idle();
		$display("Sent %0d words, checked %0d results over clamped, minimum and random sizes",
			items_sent, results_seen);
		$display("with drains, stray words, mid-frame restarts and random idling on both sides.");
		if (errors == 0 && expected_words.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/sre_pkg.sv
hdl/sre_front.sv
hdl/sre_queue.sv
hdl/sre_back.sv
hdl/sobel_rgb_edge_magnitude.sv
sim/sobel_rgb_edge_magnitude_tb.sv
